@@ src/ffha_pkg.sv @@
// Package for the first-fit heap allocator: widths, codes and shared types.
// Used by every module under src.
`default_nettype none
package ffha_pkg;
  localparam int MaxEntries = 16;
  localparam int EntryBits = $clog2(MaxEntries);
  localparam int HeapAddrBits = 16;
  localparam int SizeBits = 17;
  localparam int AccBits = 22;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StZero = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree = 1'b1;

  localparam logic CfgHeap = 1'b0;
  localparam logic CfgGranule = 1'b1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_WALK, S_SPARE, S_APPLY, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic init;      // reinitialise the list
    logic start;     // latch request, clear walk
    logic div_step;  // one quotient bit
    logic walk_step; // visit current descriptor
    logic spare_step;// examine one spare candidate
    logic apply;     // commit update
    logic set_zero;  // result: zero request
    logic set_fail;  // result: failure
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic div_done;
    logic hit;       // current descriptor matches
    logic walk_end;  // no further descriptor
    logic need_spare;
    logic spare_done;
  } dp_stat_t;
endpackage
`default_nettype wire

@@ src/ffha_ctrl.sv @@
// Controller state machine of the allocator.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl import ffha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_wr,
  input  wire logic     in_acc,
  input  wire logic     out_acc,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          in_rdy,
  output logic          out_vld
);
  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_rdy = 1'b1;
        // rebuild the list once the new register value has landed
        if (cfg_wr) begin
          state_next = S_INIT;
        end else if (in_acc) begin
          cmd.start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.is_free) state_next = S_WALK;
        else if (stat.req_zero) begin
          cmd.set_zero = 1'b1;
          state_next = S_OUT;
        end else if (stat.div_done) begin
          state_next = S_WALK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_WALK: begin
        if (stat.hit) begin
          state_next = stat.need_spare ? S_SPARE : S_APPLY;
        end else if (stat.walk_end) begin
          cmd.set_fail = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_SPARE: begin
        cmd.spare_step = 1'b1;
        if (stat.spare_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_vld = 1'b1;
        if (out_acc) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end
endmodule
`default_nettype wire

@@ src/ffha_dp.sv @@
// Datapath: descriptor table, rounding divider, list walk and update.
// Depends on ffha_pkg.
`default_nettype none
module ffha_dp import ffha_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr,
  input  wire logic                 cfg_index,
  input  wire logic [SizeBits-1:0]  cfg_data,
  input  wire dp_cmd_t              cmd,
  input  wire logic                 req_cmd,
  input  wire logic [SizeBits-1:0]  req_bytes,
  input  wire logic [15:0]          req_off,
  output dp_stat_t                  stat,
  output logic [1:0]                res_status,
  output logic [HeapAddrBits-1:0]   res_offset,
  output logic [SizeBits-1:0]       res_granted
);
  localparam logic [AccBits-1:0] Cap = AccBits'(1) << HeapAddrBits;
  localparam int CntBits = $clog2(MaxEntries + 1);

  logic [SizeBits-1:0] heap_reg, gran_reg;
  logic                use_t  [MaxEntries];
  logic [SizeBits-1:0] bytes_t[MaxEntries];
  logic [EntryBits-1:0] link_t[MaxEntries];
  logic                hasl_t [MaxEntries];

  logic                is_free;
  logic [SizeBits-1:0] req;
  logic [15:0]         foff;
  logic [SizeBits-1:0] gran;
  // divider: quotient q of (req-1)/g, restoring, one bit per cycle
  logic [SizeBits-1:0] dividend, rem, quot;
  logic [4:0]          dcnt;
  logic [AccBits-1:0]  size;
  logic [AccBits-1:0]  addr;
  logic [EntryBits-1:0] cur, back;
  logic                has_back;
  logic [CntBits-1:0]  nvis;
  logic [EntryBits-1:0] spi;
  logic                sp_found;
  logic [EntryBits-1:0] sp;
  logic                spare_done_r;

  assign gran = (gran_reg == '0) ? SizeBits'(1) : gran_reg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_reg <= SizeBits'(65536);
      gran_reg <= SizeBits'(1);
    end else if (cfg_wr) begin
      if (cfg_index == CfgHeap) heap_reg <= cfg_data;
      else gran_reg <= cfg_data;
    end
  end

  // current descriptor view
  logic                c_use, n_valid, n_use;
  logic [SizeBits-1:0] c_bytes, n_bytes;
  logic [EntryBits-1:0] nx;
  assign c_use   = use_t[cur];
  assign c_bytes = bytes_t[cur];
  assign n_valid = hasl_t[cur];
  assign nx      = link_t[cur];
  assign n_use   = use_t[nx];
  assign n_bytes = bytes_t[nx];

  logic hit;
  assign hit = is_free ? (c_use && addr == AccBits'(foff))
                       : (!c_use && AccBits'(c_bytes) >= size);

  // quotient subtract step
  logic [SizeBits:0] rem_sh;
  assign rem_sh = {rem, dividend[SizeBits-1]};

  // the rounded size is registered in the cycle after the last quotient bit
  always_comb begin
    stat.is_free    = is_free;
    stat.req_zero   = (req == '0);
    stat.div_done   = (dcnt == 5'd0);
    stat.hit        = hit;
    stat.walk_end   = !n_valid || (nvis == CntBits'(MaxEntries - 1));
    stat.need_spare = !is_free && AccBits'(c_bytes) != size && (!n_valid || n_use);
    stat.spare_done = spare_done_r;
  end

  logic [SizeBits-1:0] diff;
  assign diff = SizeBits'(AccBits'(c_bytes) - size);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < MaxEntries; i++) begin
        use_t[i] <= 1'b0; bytes_t[i] <= '0; link_t[i] <= '0; hasl_t[i] <= 1'b0;
      end
      bytes_t[0] <= (AccBits'(heap_reg) > Cap) ? SizeBits'(Cap) : heap_reg;
    end
    if (cmd.start) begin
      is_free <= req_cmd;
      req <= req_bytes;
      foff <= req_off;
      dividend <= req_bytes - SizeBits'(1);
      rem <= '0;
      quot <= '0;
      dcnt <= 5'(SizeBits);
      size <= '0;
      addr <= '0;
      cur <= '0;
      back <= '0;
      has_back <= 1'b0;
      nvis <= '0;
      spi <= EntryBits'(1);
      sp_found <= 1'b0;
      spare_done_r <= 1'b0;
      res_status <= StOk;
      res_offset <= '0;
      res_granted <= '0;
    end
    if (cmd.div_step) begin
      dividend <= dividend << 1;
      if (rem_sh >= {1'b0, gran}) begin
        rem <= SizeBits'(rem_sh - {1'b0, gran});
        quot <= {quot[SizeBits-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SizeBits-1:0];
        quot <= {quot[SizeBits-2:0], 1'b0};
      end
      dcnt <= dcnt - 5'd1;
    end
    // size = (q+1)*g once the divider finishes (saturated: large never fits)
    if (dcnt == 5'd0 && !cmd.start) begin
      size <= (({5'b0, quot} + AccBits'(1)) * AccBits'(gran) > AccBits'(Cap))
              ? AccBits'(Cap) + AccBits'(1)
              : ({5'b0, quot} + AccBits'(1)) * AccBits'(gran);
    end
    if (cmd.walk_step) begin
      addr <= addr + AccBits'(c_bytes);
      back <= cur;
      has_back <= 1'b1;
      cur <= nx;
      nvis <= nvis + CntBits'(1);
    end
    if (cmd.spare_step) begin
      if (!use_t[spi] && bytes_t[spi] == '0 && !sp_found) begin
        sp_found <= 1'b1;
        sp <= spi;
      end
      if (spi == EntryBits'(MaxEntries - 1)) spare_done_r <= 1'b1;
      else spi <= spi + EntryBits'(1);
    end
    if (cmd.set_zero) res_status <= StZero;
    if (cmd.set_fail) res_status <= is_free ? StNotFound : StNoFit;
    if (cmd.apply) begin
      res_status <= StOk;
      if (is_free) begin
        res_offset <= foff;
        use_t[cur] <= 1'b0;
        if (has_back && !use_t[back]) begin
          if (n_valid && !n_use) begin
            bytes_t[back] <= bytes_t[back] + c_bytes + n_bytes;
            link_t[back] <= link_t[nx];
            hasl_t[back] <= hasl_t[nx];
            bytes_t[nx] <= '0; link_t[nx] <= '0; hasl_t[nx] <= 1'b0;
          end else begin
            bytes_t[back] <= bytes_t[back] + c_bytes;
            link_t[back] <= nx;
            hasl_t[back] <= n_valid;
          end
          bytes_t[cur] <= '0; link_t[cur] <= '0; hasl_t[cur] <= 1'b0;
        end else if (n_valid && !n_use) begin
          bytes_t[cur] <= c_bytes + n_bytes;
          link_t[cur] <= link_t[nx];
          hasl_t[cur] <= hasl_t[nx];
          bytes_t[nx] <= '0; link_t[nx] <= '0; hasl_t[nx] <= 1'b0;
        end
      end else begin
        use_t[cur] <= 1'b1;
        res_offset <= addr[HeapAddrBits-1:0];
        res_granted <= c_bytes;
        if (AccBits'(c_bytes) != size) begin
          if (n_valid && !n_use) begin
            bytes_t[nx] <= n_bytes + diff;
            bytes_t[cur] <= SizeBits'(size);
            res_granted <= SizeBits'(size);
          end else if (sp_found) begin
            bytes_t[sp] <= diff;
            link_t[sp] <= nx;
            hasl_t[sp] <= n_valid;
            bytes_t[cur] <= SizeBits'(size);
            link_t[cur] <= sp;
            hasl_t[cur] <= 1'b1;
            res_granted <= SizeBits'(size);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ src/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator; joins controller and datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_dp.
// An allocate runs the divider, walks the descriptors, searches the spare pool when a split
// needs a spare and commits the grant; a free skips the divider, walks the descriptors and
// commits on success; a zero-size request skips the walk.
// One request at a time; the divider and the list walk set the rate.
// Synchronous reset, then the list is rebuilt in the init state; a configuration write does the same.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // request_bytes[16:0], free_offset[32:17]
  input  wire logic        s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // region_offset[15:0], granted_bytes[32:16]
  output logic [1:0]       m_tuser,   // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic in_rdy, cfg_wr;
  logic [HeapAddrBits-1:0] off;
  logic [SizeBits-1:0] got;

  // take configuration only while idle
  assign cfg_ready = in_rdy;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign s_tready = in_rdy && !cfg_valid;

  ffha_ctrl u_ctrl (
    .clk, .rst, .cfg_wr, .in_acc(s_tvalid && s_tready), .out_acc(m_tvalid && m_tready),
    .stat, .cmd, .in_rdy, .out_vld(m_tvalid)
  );

  ffha_dp u_dp (
    .clk, .rst, .cfg_wr, .cfg_index, .cfg_data, .cmd,
    .req_cmd(s_tuser), .req_bytes(s_tdata[16:0]), .req_off(s_tdata[32:17]),
    .stat, .res_status(m_tuser), .res_offset(off), .res_granted(got)
  );

  assign m_tdata = {7'b0, got, off};

  // walk and result never overlap an accepted input
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input accepted while result pending");
  // result held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  // any result other than OK reports zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != StOk |-> m_tdata == '0) else $error("failure carries data");
endmodule
`default_nettype wire

@@ dv/ffha_checker.sv @@
// Checker for the first-fit heap allocator: watches request, configuration and
// result channels, predicts each result and compares it. Depends on ffha_pkg.
`timescale 1ns / 100ps
module ffha_checker import ffha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,   // request_bytes[16:0], free_offset[32:17]
  input  wire logic        s_tuser,   // cmd
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,   // region_offset[15:0], granted_bytes[32:16]
  input  wire logic [1:0]  m_tuser,   // status
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               checked
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [16:0] granted;
  } grant_t;

  grant_t grant_q[$];

  // predicted allocator state
  longint heap_reg, granule_reg;
  logic   desc_used [MaxEntries];
  longint desc_bytes [MaxEntries];
  int     desc_next [MaxEntries];
  logic   desc_linked [MaxEntries];

  assign pending = grant_q.size();

  function automatic void rebuild_list();
    for (int i = 0; i < MaxEntries; i++) begin
      desc_used[i] = 0;
      desc_bytes[i] = 0;
      desc_next[i] = 0;
      desc_linked[i] = 0;
    end
    desc_bytes[0] = (heap_reg > (64'd1 << HeapAddrBits)) ? (64'd1 << HeapAddrBits) : heap_reg;
  endfunction

  // lowest spare descriptor, -1 when the pool is exhausted
  function automatic int find_spare();
    for (int i = 1; i < MaxEntries; i++)
      if (!desc_used[i] && desc_bytes[i] == 0) return i;
    return -1;
  endfunction

  function automatic grant_t serve_alloc(longint req);
    grant_t r;
    longint g, size, addr, diff;
    int cur, nx, sp;
    r = '0;
    g = (granule_reg != 0) ? granule_reg : 1;
    addr = 0;
    cur = 0;
    if (req == 0) begin
      r.status = StZero;
      return r;
    end
    size = (1 + (req - 1) / g) * g;
    for (int n = 0; n < MaxEntries; n++) begin
      if (!desc_used[cur] && desc_bytes[cur] >= size) begin
        desc_used[cur] = 1;
        if (desc_bytes[cur] != size) begin
          diff = desc_bytes[cur] - size;
          nx = desc_next[cur];
          if (!desc_linked[cur] || desc_used[nx]) begin
            // split into a spare descriptor, or grant whole region if none
            sp = find_spare();
            if (sp >= 0) begin
              desc_bytes[sp] = diff;
              desc_linked[sp] = desc_linked[cur];
              desc_next[sp] = desc_linked[cur] ? nx : 0;
              desc_bytes[cur] = size;
              desc_next[cur] = sp;
              desc_linked[cur] = 1;
            end
          end else begin
            desc_bytes[nx] += diff;
            desc_bytes[cur] = size;
          end
        end
        r.status = StOk;
        r.offset = addr[15:0];
        r.granted = desc_bytes[cur][16:0];
        return r;
      end
      addr += desc_bytes[cur];
      if (!desc_linked[cur]) break;
      cur = desc_next[cur];
    end
    r.status = StNoFit;
    return r;
  endfunction

  function automatic grant_t serve_free(longint foff);
    grant_t r;
    longint addr;
    int cur, back, nx;
    logic has_back, has_next;
    r = '0;
    addr = 0;
    cur = 0;
    back = 0;
    has_back = 0;
    for (int n = 0; n < MaxEntries; n++) begin
      has_next = desc_linked[cur];
      nx = desc_next[cur];
      if (desc_used[cur] && addr == foff) begin
        desc_used[cur] = 0;
        // absorb into a free predecessor
        if (has_back && !desc_used[back]) begin
          desc_bytes[back] += desc_bytes[cur];
          desc_next[back] = desc_next[cur];
          desc_linked[back] = desc_linked[cur];
          desc_bytes[cur] = 0;
          desc_next[cur] = 0;
          desc_linked[cur] = 0;
          cur = back;
        end
        // absorb a free successor
        if (has_next && !desc_used[nx]) begin
          desc_bytes[cur] += desc_bytes[nx];
          desc_next[cur] = desc_next[nx];
          desc_linked[cur] = desc_linked[nx];
          desc_bytes[nx] = 0;
          desc_next[nx] = 0;
          desc_linked[nx] = 0;
        end
        r.status = StOk;
        r.offset = foff[15:0];
        return r;
      end
      addr += desc_bytes[cur];
      if (!has_next) break;
      back = cur;
      has_back = 1;
      cur = nx;
    end
    r.status = StNotFound;
    return r;
  endfunction

  // observe transactions and compare
  always @(posedge clk) begin
    grant_t got, exp;
    if (rst) begin
      heap_reg = 65536;
      granule_reg = 1;
      rebuild_list();
      grant_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgHeap) heap_reg = cfg_data;
        else granule_reg = cfg_data;
        rebuild_list();
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CmdFree) grant_q.push_back(serve_free(s_tdata[32:17]));
        else grant_q.push_back(serve_alloc(s_tdata[16:0]));
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.offset = m_tdata[15:0];
        got.granted = m_tdata[32:16];
        checked <= checked + 1;
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d offset=%0d granted=%0d",
                   $time, got.status, got.offset, got.granted);
          fail_count <= fail_count + 1;
        end else begin
          exp = grant_q.pop_front();
          if (got !== exp) begin
            $display("%0t: mismatch expected status=%0d offset=%0d granted=%0d",
                     $time, exp.status, exp.offset, exp.granted);
            $display("%0t:          actual   status=%0d offset=%0d granted=%0d",
                     $time, got.status, got.offset, got.granted);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// Testbench top for the first-fit heap allocator: clock, reset, stimulus and
// verdict. Depends on ffha_pkg, ffha_checker and first_fit_heap_allocator.
`timescale 1ns / 100ps
module testbench;
  import ffha_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int ItemsPerPhase = 120;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // request_bytes[16:0], free_offset[32:17]
  logic        s_tuser = 0;   // cmd
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;       // region_offset[15:0], granted_bytes[32:16]
  logic [1:0]  m_tuser;       // status
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [16:0] cfg_data = '0;

  int fail_count, pending, checked;
  int idle_cycles = 0;
  int stall_left = 0;
  int phases_run = 0;
  logic calm = 1;
  longint heap_size = 65536;
  logic [15:0] live_offsets[$];

  first_fit_heap_allocator dut (.*);

  ffha_checker chk (.*);

  always #1 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // result side: random back-pressure unless in a calm stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  // record granted regions so that frees can name live offsets
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready && m_tuser == StOk && m_tdata[32:16] != 0)
      live_offsets.push_back(m_tdata[15:0]);

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_request(logic cmd, logic [16:0] req, logic [15:0] off);
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, off, req};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold off the next request for a random gap
  task automatic pause_sender();
    int gap;
    gap = calm ? 0 : (($urandom_range(0, 2) == 0) ? gap_len() : 0);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let the checker see the last transaction before waiting for results
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(logic [16:0] heap, logic [16:0] gran);
    drain();
    write_reg(CfgHeap, heap);
    write_reg(CfgGranule, gran);
    cfg_valid <= 0;
    heap_size = (heap > 65536) ? 65536 : heap;
    live_offsets.delete();
    phases_run++;
  endtask

  // random request: mostly well-formed frees of live regions and modest sizes
  task automatic random_request();
    int pick, idx;
    logic [16:0] req;
    logic [15:0] off;
    req = 17'($urandom_range(0, 65536));
    off = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 9);
    if (pick < 4 && live_offsets.size() > 0) begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      off = live_offsets[idx];
      live_offsets.delete(idx);
      send_request(CmdFree, req, off);
    end else if (pick == 4) begin
      send_request(CmdFree, req, off);
    end else begin
      if (pick != 9) req = 17'($urandom_range(1, heap_size / 8 + 2));
      send_request(CmdAlloc, req, off);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed checks on the reset configuration
    send_request(CmdAlloc, 17'd0, 16'd0);
    send_request(CmdAlloc, 17'd65536, 16'hffff);
    send_request(CmdAlloc, 17'd1, 16'd0);
    send_request(CmdFree, 17'h1ffff, 16'd1);
    send_request(CmdFree, 17'd0, 16'd0);
    send_request(CmdAlloc, 17'd100, 16'd0);
    send_request(CmdAlloc, 17'd200, 16'd0);
    send_request(CmdAlloc, 17'd300, 16'd0);
    send_request(CmdFree, 17'd0, 16'd100);
    send_request(CmdFree, 17'd0, 16'd0);
    send_request(CmdFree, 17'd0, 16'd300);
    send_request(CmdFree, 17'd0, 16'd600);
    send_request(CmdAlloc, 17'd65535, 16'd0);
    send_request(CmdAlloc, 17'd1, 16'd0);
    send_request(CmdFree, 17'd0, 16'hffff);
    send_request(CmdFree, 17'd0, 16'd0);
    // exhaust the descriptor pool so that a whole region is granted
    for (int i = 0; i < 18; i++) send_request(CmdAlloc, 17'd4, 16'd0);

    // random phases over several settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: reconfigure(17'd65536, 17'd1);
        1: reconfigure(17'd100, 17'd7);
        2: reconfigure(17'd0, 17'd0);
        3: reconfigure(17'h1ffff, 17'd65536);
        4: reconfigure(17'd1, 17'd1);
        default: reconfigure(17'($urandom_range(1, 131071)), 17'($urandom_range(0, 300)));
      endcase
      calm = (p % 3 == 0);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        random_request();
        pause_sender();
      end
    end

    drain();
    $display("Covered %0d results over %0d settings, with random gaps and stalls on both sides.",
             checked, phases_run + 1);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
